// ===== design/cvs_pkg.sv =====
package cvs_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_ZERO      = 3'd1;
   localparam logic [2:0] STAT_MISMATCH  = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_TOO_LONG  = 3'd4;
   localparam logic [2:0] STAT_NO_ANSWER = 3'd5;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] element;
      logic               last_element;
      logic [15:0]        chunk_id;
      logic [15:0]        document_id;
      logic [6:0]         top_k;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [15:0]        result_chunk;
      logic signed [15:0] score;
      logic [5:0]         rank;
      logic               last_result;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_RM_META,
      ST_RM_CHECK,
      ST_RM_RD,
      ST_RM_WR,
      ST_Q_SQB,
      ST_Q_META,
      ST_Q_LOAD,
      ST_Q_SQA,
      ST_Q_DOT_RD,
      ST_Q_DOT_MAC,
      ST_Q_MUL,
      ST_Q_DIVI,
      ST_Q_DIV,
      ST_Q_STORE,
      ST_RK_INIT,
      ST_RK_SCAN,
      ST_RK_CHUNK,
      ST_RK_OUT,
      ST_RESP
   } state_type;

endpackage

// ===== design/cvs_ram.sv =====
module cvs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/cosine_topk_vector_search_core.sv =====
// Channel  Direction  Payload   Handshake
// req      in         req_type  req_valid / req_ready
// rsp      out        rsp_type  rsp_valid / rsp_ready
//
// A non-final component is staged as it is accepted; a final one is followed
// by the checks and then the sequencer work.
// Add copies the vector component by component through a read and a write state;
// remove copies each kept entry behind a deleted one in the same way.
// Query: per entry, work in turn on the shared square root, MAC and divider,
// then a scan over all entries for each ranked result.
// Reset is synchronous and clears the FSM state, store count, stored length and staging state only.
// Intake stalls from the final component (or a remove or clear request) until the last result is taken.
module cosine_topk_vector_search_core import cvs_pkg::*; #(
   parameter int MAX_ENTRIES = 64,
   parameter int DIM         = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW   = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int DW   = DIM > 1 ? $clog2(DIM) : 1;
   localparam int LW   = $clog2(DIM + 1);
   localparam int SD   = MAX_ENTRIES * DIM;
   localparam int SAW  = SD > 1 ? $clog2(SD) : 1;
   localparam int NW   = 32 + $clog2(DIM);
   localparam int RW   = (NW + 1) / 2;
   localparam int SVW  = 2 * RW;
   localparam int NMW  = 2 * RW + 18;
   localparam int MW   = NW + 32;

   state_type state_ff, state_in;
   logic [LW-1:0]   len_ff, len_in;
   logic [NW-1:0]   norm_ff, norm_in;
   logic            nz_ff, nz_in, ov_ff, ov_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [LW-1:0]   sd_ff, sd_in;

   logic [1:0]      op_ff, op_in;
   logic [15:0]     chunk_ff, chunk_in, doc_ff, doc_in;
   logic [6:0]      kcnt_ff, kcnt_in, k_ff, k_in;
   logic [CW-1:0]   i_ff, i_in, w_ff, w_in;
   logic [LW-1:0]   j_ff, j_in;
   logic [MW-1:0]   mhold_ff, mhold_in;
   logic signed [NW:0] acc_ff, acc_in;
   logic [SVW-1:0]  sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [RW-1:0]   rb_ff, rb_in;
   logic [SVW-1:0]  den_ff, den_in;
   logic [NMW-1:0]  rem_ff, rem_in, dv_ff, dv_in;
   logic [14:0]     quo_ff, quo_in;
   logic            sat_ff, sat_in, neg_ff, neg_in;
   logic [3:0]      b_ff, b_in;
   logic [MAX_ENTRIES-1:0] used_ff, used_in;
   logic [IW-1:0]   best_ff, best_in, pi_ff, pi_in;
   logic signed [15:0] best_sc_ff, best_sc_in;
   logic            found_ff, found_in, pv_ff, pv_in;
   rsp_type         rsp_ff, rsp_in;

   logic            st_we, q_we, m_we, s_we;
   logic [CW-1:0]   st_rrow, st_wrow;
   logic [LW-1:0]   st_rcol, st_wcol;
   logic [SAW:0]    st_ra_full, st_wa_full;
   logic [15:0]     st_wd, st_rd, q_wd, q_rd, s_wd, s_rd;
   logic [DW-1:0]   q_wa, q_ra;
   logic [IW-1:0]   m_wa, m_ra, s_wa, s_ra;
   logic [MW-1:0]   m_wd, m_rd;

   logic signed [31:0] el_sq;
   logic signed [31:0] prod;
   logic [SVW-1:0]  sq_sum;
   logic            sq_ge;
   logic [NW:0]     mag;
   logic [NMW-1:0]  num, dv_full, dv_sh;

   assign st_ra_full = (SAW+1)'(st_rrow) * (SAW+1)'(DIM) + (SAW+1)'(st_rcol);
   assign st_wa_full = (SAW+1)'(st_wrow) * (SAW+1)'(DIM) + (SAW+1)'(st_wcol);

   assign el_sq   = req_data.element * req_data.element;
   assign prod    = $signed(st_rd) * $signed(q_rd);
   assign sq_sum  = sq_r_ff + sq_bit_ff;
   assign sq_ge   = sq_v_ff >= sq_sum;
   assign mag     = acc_ff[NW] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
   assign num     = (NMW'(mag) << 16) + NMW'(den_ff);
   assign dv_full = NMW'({den_ff, 1'b0});
   assign dv_sh   = dv_ff << b_ff;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_RESP;
   assign rsp_data  = rsp_ff;

   cvs_ram #(.WIDTH(16), .DEPTH(SD)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa_full[SAW-1:0]), .wr_data(st_wd),
      .rd_addr(st_ra_full[SAW-1:0]), .rd_data(st_rd));
   cvs_ram #(.WIDTH(16), .DEPTH(DIM)) u_query (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));
   cvs_ram #(.WIDTH(MW), .DEPTH(MAX_ENTRIES)) u_meta (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   cvs_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_score (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));

   always_comb begin
      logic [CW-1:0] i_nx;
      logic [CW-1:0] w_nx;
      logic          rm_adv;
      logic signed [15:0] sc;
      state_in   = state_ff;
      len_in     = len_ff;
      norm_in    = norm_ff;
      nz_in      = nz_ff;
      ov_in      = ov_ff;
      count_in   = count_ff;
      sd_in      = sd_ff;
      op_in      = op_ff;
      chunk_in   = chunk_ff;
      doc_in     = doc_ff;
      kcnt_in    = kcnt_ff;
      k_in       = k_ff;
      i_in       = i_ff;
      w_in       = w_ff;
      j_in       = j_ff;
      mhold_in   = mhold_ff;
      acc_in     = acc_ff;
      sq_v_in    = sq_v_ff;
      sq_r_in    = sq_r_ff;
      sq_bit_in  = sq_bit_ff;
      rb_in      = rb_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      dv_in      = dv_ff;
      quo_in     = quo_ff;
      sat_in     = sat_ff;
      neg_in     = neg_ff;
      b_in       = b_ff;
      used_in    = used_ff;
      best_in    = best_ff;
      pi_in      = pi_ff;
      best_sc_in = best_sc_ff;
      found_in   = found_ff;
      pv_in      = pv_ff;
      rsp_in     = rsp_ff;
      st_we = 1'b0; q_we = 1'b0; m_we = 1'b0; s_we = 1'b0;
      st_rrow = i_ff;
      st_rcol = j_ff;
      st_wrow = w_ff;
      st_wcol = j_ff;
      st_wd = st_rd;
      q_wa = len_ff[DW-1:0];
      q_wd = req_data.element;
      q_ra = j_ff[DW-1:0];
      m_wa = w_ff[IW-1:0];
      m_wd = mhold_ff;
      m_ra = i_ff[IW-1:0];
      s_wa = i_ff[IW-1:0];
      s_wd = 16'(0);
      s_ra = i_ff[IW-1:0];
      i_nx = i_ff + CW'(1);
      w_nx = w_ff;
      rm_adv = 1'b0;
      sc = 16'sd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.op;
               chunk_in = req_data.chunk_id;
               doc_in   = req_data.document_id;
               rsp_in   = '{STAT_OK, 16'd0, 16'sd0, 6'd0, 1'b1};
               if (req_data.op == OP_CLEAR) begin
                  count_in = '0;
                  sd_in    = '0;
                  state_in = ST_RESP;
               end else if (req_data.op == OP_REMOVE) begin
                  i_in = '0;
                  w_in = '0;
                  if (count_ff == '0) begin
                     sd_in    = '0;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_RM_META;
                  end
               end else begin
                  if (len_ff < LW'(DIM)) begin
                     q_we    = 1'b1;
                     len_in  = len_ff + LW'(1);
                     norm_in = norm_ff + NW'($unsigned(el_sq));
                     if (req_data.element != 16'sd0) begin
                        nz_in = 1'b1;
                     end
                  end else begin
                     ov_in = 1'b1;
                  end
                  if (req_data.last_element) begin
                     kcnt_in  = (req_data.top_k < 7'(count_ff)) ? req_data.top_k
                                                                : 7'(count_ff);
                     state_in = ST_DECIDE;
                  end
               end
            end
         end
         ST_DECIDE: begin
            j_in     = '0;
            state_in = ST_RESP;
            if (op_ff == OP_ADD) begin
               priority if (ov_ff) begin
                  rsp_in.status = STAT_TOO_LONG;
               end else if (!nz_ff) begin
                  rsp_in.status = STAT_ZERO;
               end else if (count_ff != '0 && len_ff != sd_ff) begin
                  rsp_in.status = STAT_MISMATCH;
               end else if (count_ff >= CW'(MAX_ENTRIES)) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  state_in = ST_ADD_RD;
               end
            end else begin
               priority if (kcnt_ff == 7'd0) begin
                  rsp_in.status = STAT_NO_ANSWER;
               end else if (ov_ff) begin
                  rsp_in.status = STAT_TOO_LONG;
               end else if (!nz_ff) begin
                  rsp_in.status = STAT_ZERO;
               end else if (len_ff != sd_ff) begin
                  rsp_in.status = STAT_MISMATCH;
               end else begin
                  sq_v_in   = SVW'(norm_ff);
                  sq_r_in   = '0;
                  sq_bit_in = SVW'(1) << (SVW - 2);
                  i_in      = '0;
                  k_in      = '0;
                  used_in   = '0;
                  state_in  = ST_Q_SQB;
               end
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            st_we   = 1'b1;
            st_wrow = count_ff;
            st_wd   = q_rd;
            j_in    = j_ff + LW'(1);
            if (j_in == len_ff) begin
               m_we = 1'b1;
               m_wa = count_ff[IW-1:0];
               m_wd = {norm_ff, chunk_ff, doc_ff};
               if (count_ff == '0) begin
                  sd_in = len_ff;
               end
               count_in = count_ff + CW'(1);
               state_in = ST_RESP;
            end else begin
               state_in = ST_ADD_RD;
            end
         end
         ST_RM_META: begin
            state_in = ST_RM_CHECK;
         end
         ST_RM_CHECK: begin
            mhold_in = m_rd;
            j_in     = '0;
            if (m_rd[15:0] == doc_ff) begin
               rm_adv = 1'b1;
            end else if (w_ff != i_ff) begin
               state_in = ST_RM_RD;
            end else begin
               w_nx   = w_ff + CW'(1);
               rm_adv = 1'b1;
            end
         end
         ST_RM_RD: begin
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            st_we = 1'b1;
            j_in  = j_ff + LW'(1);
            if (j_in == sd_ff) begin
               m_we   = 1'b1;
               w_nx   = w_ff + CW'(1);
               rm_adv = 1'b1;
            end else begin
               state_in = ST_RM_RD;
            end
         end
         ST_Q_SQB, ST_Q_SQA: begin
            if (sq_bit_ff != '0) begin
               if (sq_ge) begin
                  sq_v_in = sq_v_ff - sq_sum;
                  sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_in = sq_r_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end else if (state_ff == ST_Q_SQB) begin
               rb_in    = sq_r_ff[RW-1:0];
               state_in = ST_Q_META;
            end else begin
               j_in     = '0;
               acc_in   = '0;
               state_in = ST_Q_DOT_RD;
            end
         end
         ST_Q_META: begin
            state_in = ST_Q_LOAD;
         end
         ST_Q_LOAD: begin
            sq_v_in   = SVW'(m_rd[MW-1:32]);
            sq_r_in   = '0;
            sq_bit_in = SVW'(1) << (SVW - 2);
            state_in  = ST_Q_SQA;
         end
         ST_Q_DOT_RD: begin
            state_in = ST_Q_DOT_MAC;
         end
         ST_Q_DOT_MAC: begin
            acc_in = acc_ff + (NW+1)'(prod);
            j_in   = j_ff + LW'(1);
            state_in = (j_in == len_ff) ? ST_Q_MUL : ST_Q_DOT_RD;
         end
         ST_Q_MUL: begin
            den_in = SVW'(sq_r_ff[RW-1:0]) * SVW'(rb_ff);
            if (den_in == '0) begin
               den_in = SVW'(1);
            end
            state_in = ST_Q_DIVI;
         end
         ST_Q_DIVI: begin
            neg_in = acc_ff[NW];
            dv_in  = dv_full;
            rem_in = num;
            quo_in = '0;
            b_in   = 4'd14;
            sat_in = num >= (dv_full << 15);
            state_in = sat_in ? ST_Q_STORE : ST_Q_DIV;
         end
         ST_Q_DIV: begin
            if (rem_ff >= dv_sh) begin
               rem_in = rem_ff - dv_sh;
               quo_in[b_ff] = 1'b1;
            end
            b_in = b_ff - 4'd1;
            if (b_ff == 4'd0) begin
               state_in = ST_Q_STORE;
            end
         end
         ST_Q_STORE: begin
            if (neg_ff) begin
               sc = sat_ff ? -16'sd32768 : -$signed({1'b0, quo_ff});
            end else begin
               sc = sat_ff ? 16'sd32767 : $signed({1'b0, quo_ff});
            end
            s_we = 1'b1;
            s_wd = sc;
            i_in = i_nx;
            state_in = (i_nx == count_ff) ? ST_RK_INIT : ST_Q_META;
         end
         ST_RK_INIT: begin
            i_in     = '0;
            found_in = 1'b0;
            pv_in    = 1'b0;
            state_in = ST_RK_SCAN;
         end
         ST_RK_SCAN: begin
            if (pv_ff && !used_ff[pi_ff] && (!found_ff || $signed(s_rd) > best_sc_ff)) begin
               best_in    = pi_ff;
               best_sc_in = $signed(s_rd);
               found_in   = 1'b1;
            end
            if (i_ff != count_ff) begin
               pv_in = 1'b1;
               pi_in = i_ff[IW-1:0];
               i_in  = i_nx;
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  state_in = ST_RK_CHUNK;
               end
            end
         end
         ST_RK_CHUNK: begin
            m_ra     = best_ff;
            state_in = ST_RK_OUT;
         end
         ST_RK_OUT: begin
            used_in[best_ff] = 1'b1;
            rsp_in = '{STAT_OK, m_rd[31:16], best_sc_ff, k_ff[5:0],
                       (k_ff + 7'd1) == kcnt_ff};
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               if (rsp_ff.last_result) begin
                  len_in   = '0;
                  norm_in  = '0;
                  nz_in    = 1'b0;
                  ov_in    = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 7'd1;
                  state_in = ST_RK_INIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rm_adv) begin
         w_in = w_nx;
         i_in = i_nx;
         if (i_nx == count_ff) begin
            count_in = w_nx;
            if (w_nx == '0) begin
               sd_in = '0;
            end
            state_in = ST_RESP;
         end else begin
            state_in = ST_RM_META;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         norm_ff  <= '0;
         nz_ff    <= 1'b0;
         ov_ff    <= 1'b0;
         count_ff <= '0;
         sd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         norm_ff  <= norm_in;
         nz_ff    <= nz_in;
         ov_ff    <= ov_in;
         count_ff <= count_in;
         sd_ff    <= sd_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      chunk_ff   <= chunk_in;
      doc_ff     <= doc_in;
      kcnt_ff    <= kcnt_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      w_ff       <= w_in;
      j_ff       <= j_in;
      mhold_ff   <= mhold_in;
      acc_ff     <= acc_in;
      sq_v_ff    <= sq_v_in;
      sq_r_ff    <= sq_r_in;
      sq_bit_ff  <= sq_bit_in;
      rb_ff      <= rb_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      dv_ff      <= dv_in;
      quo_ff     <= quo_in;
      sat_ff     <= sat_in;
      neg_ff     <= neg_in;
      b_ff       <= b_in;
      used_ff    <= used_in;
      best_ff    <= best_in;
      pi_ff      <= pi_in;
      best_sc_ff <= best_sc_in;
      found_ff   <= found_in;
      pv_ff      <= pv_in;
      rsp_ff     <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("intake open while a result is pending");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond capacity");
   assert property (@(posedge clock) disable iff (reset) (count_ff == '0) |-> (sd_ff == '0))
      else $error("stored length kept with an empty store");
   assert property (@(posedge clock) disable iff (reset) len_ff <= LW'(DIM))
      else $error("staged length beyond dimension");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> req_ready)
      else $error("intake not reopened after final result");

endmodule
